@@ design/motion_reply_line_parser_unit_assert.svh @@
// ----------------------------------------------------------------------------
// motion reply line parser assertion macros
// shared property forms for the parser checks
// ----------------------------------------------------------------------------
`ifndef MOTION_REPLY_LINE_PARSER_UNIT_ASSERT_SVH
`define MOTION_REPLY_LINE_PARSER_UNIT_ASSERT_SVH

// condition in one cycle implies a consequence in the next
`define MRLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// condition implies a consequence in the same cycle
`define MRLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/mrlp_pkg.sv @@
// ----------------------------------------------------------------------------
// mrlp_pkg
// types, character codes and keyword tables for the motion reply line parser
// ----------------------------------------------------------------------------
package mrlp_pkg;

  localparam int unsigned LINE_BYTES = 128;
  localparam int unsigned POS_W      = $clog2(LINE_BYTES);
  localparam int unsigned FIELDS     = 6;
  localparam int unsigned FIELD_W    = $clog2(FIELDS + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_S     = 8'h53;

  localparam logic [31:0] NUM_SAT = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    KIND_IGNORED   = 2'd0,
    KIND_RESPONSE  = 2'd1,
    KIND_BROADCAST = 2'd2,
    KIND_STATUS    = 2'd3
  } line_kind_e;

  typedef enum logic [1:0] {
    REPLY_NONE    = 2'd0,
    REPLY_OK      = 2'd1,
    REPLY_FAIL    = 2'd2,
    REPLY_ARRIVED = 2'd3
  } reply_e;

  typedef enum logic [1:0] {
    STAT_UNKNOWN = 2'd0,
    STAT_STOPPED = 2'd1,
    STAT_MOVING  = 2'd2,
    STAT_PAUSED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    WORD_STOPPED = 2'd0,
    WORD_MOVING  = 2'd1,
    WORD_PAUSED  = 2'd2
  } word_e;

  // keyword character at a given match position
  function automatic logic [7:0] word_char(input word_e w, input logic [2:0] p);
    logic [7:0] ch;
    ch = CH_NUL;
    case (w)
      WORD_STOPPED: begin
        case (p)
          3'd0: ch = 8'h53;
          3'd1: ch = 8'h54;
          3'd2: ch = 8'h4F;
          3'd3: ch = 8'h50;
          3'd4: ch = 8'h50;
          3'd5: ch = 8'h45;
          3'd6: ch = 8'h44;
          default: ch = CH_NUL;
        endcase
      end
      WORD_MOVING: begin
        case (p)
          3'd0: ch = 8'h4D;
          3'd1: ch = 8'h4F;
          3'd2: ch = 8'h56;
          3'd3: ch = 8'h49;
          3'd4: ch = 8'h4E;
          3'd5: ch = 8'h47;
          default: ch = CH_NUL;
        endcase
      end
      WORD_PAUSED: begin
        case (p)
          3'd0: ch = 8'h50;
          3'd1: ch = 8'h41;
          3'd2: ch = 8'h55;
          3'd3: ch = 8'h53;
          3'd4: ch = 8'h45;
          3'd5: ch = 8'h44;
          default: ch = CH_NUL;
        endcase
      end
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] word_len(input word_e w);
    logic [2:0] n;
    case (w)
      WORD_STOPPED: n = 3'd7;
      WORD_MOVING:  n = 3'd6;
      WORD_PAUSED:  n = 3'd6;
      default:      n = 3'd7;
    endcase
    return n;
  endfunction

endpackage

@@ design/motion_reply_line_parser_unit.sv @@
// ----------------------------------------------------------------------------
// motion_reply_line_parser_unit
// splits received controller bytes into lines and decodes replies,
// six-value broadcasts and status lines as they stream in
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  rx      | in        | rx_valid_i / rx_ready_o   | rx_byte_i
//  res     | out       | res_valid_o / res_ready_i | line_kind_o and held values
//
//  one byte is taken per cycle while rx_ready_o is high; a newline gives its result in the cycle after
//  its transfer; bytes other than newline give no result
//  the result register is the only stage: rx stalls only while a result waits
//  and res_ready_i is low
//  reset clears all line and held state at once, apart from the pending field values
module motion_reply_line_parser_unit
  import mrlp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [1:0]         line_kind_o,
  output logic [1:0]         last_reply_o,
  output logic [1:0]         motion_status_o,
  output logic signed [31:0] pose_x_o,
  output logic signed [31:0] pose_y_o,
  output logic signed [31:0] pose_heading_o,
  output logic signed [31:0] speed_x_o,
  output logic signed [31:0] speed_y_o,
  output logic signed [31:0] speed_heading_o,
  output logic               pose_valid_o
);

  `include "motion_reply_line_parser_unit_assert.svh"

  logic               rx_xfer;

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [7:0]         lead_q, lead_d;
  logic               ended_q, ended_d;
  logic [FIELD_W-1:0] field_q, field_d;
  phase_e             phase_q, phase_d;
  logic               neg_q, neg_d;
  logic [31:0]        accum_q, accum_d;
  logic               failed_q, failed_d;
  logic [2:0]         prog_q [3];
  logic [2:0]         prog_d [3];
  logic [2:0]         found_q, found_d;
  logic [31:0]        pend_q [FIELDS];
  logic [31:0]        pend_d [FIELDS];
  logic [31:0]        held_q [FIELDS];
  logic [31:0]        held_d [FIELDS];
  logic               hvalid_q, hvalid_d;
  reply_e             reply_q, reply_d;
  status_e            status_q, status_d;
  line_kind_e         kind_q, kind_d;
  logic               res_valid_q, res_valid_d;

  // number scanner
  logic [7:0]         fc;
  logic               feed_en;
  logic               fc_digit;
  logic [35:0]        acc10;
  logic [31:0]        acc_sat;
  logic [31:0]        commit_val;
  logic [FIELD_W-1:0] fd_field;
  phase_e             fd_phase;
  logic               fd_neg;
  logic [31:0]        fd_accum;
  logic               fd_failed;
  logic               fd_we;
  logic               fd_go;

  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign rx_xfer    = rx_valid_i && rx_ready_o;

  assign fc       = (rx_byte_i == CH_LF) ? CH_NUL : rx_byte_i;
  assign fc_digit = (fc >= CH_ZERO) && (fc <= CH_NINE);
  assign acc10    = ({4'd0, accum_q} << 3) + ({4'd0, accum_q} << 1) + {32'd0, fc[3:0]};
  assign acc_sat  = (acc10 > {4'd0, NUM_SAT}) ? NUM_SAT : acc10[31:0];
  assign commit_val = neg_q ? (32'd0 - accum_q)
                            : ((accum_q > INT_MAX) ? INT_MAX : accum_q);

  always_comb begin
    fd_field  = field_q;
    fd_phase  = phase_q;
    fd_neg    = neg_q;
    fd_accum  = accum_q;
    fd_failed = failed_q;
    fd_we     = 1'b0;
    fd_go     = 1'b0;
    if (!failed_q && (field_q < FIELD_W'(FIELDS))) begin
      fd_go = 1'b1;
      if (phase_q == PH_DIGITS) begin
        fd_go = 1'b0;
        if (fc_digit) begin
          fd_accum = acc_sat;
        end else begin
          fd_we    = 1'b1;
          fd_field = field_q + FIELD_W'(1);
          fd_phase = PH_IDLE;
          fd_neg   = 1'b0;
          fd_accum = '0;
          fd_go    = (fd_field < FIELD_W'(FIELDS));
        end
      end
      if (fd_go) begin
        case (fd_phase)
          PH_SIGN: begin
            if (fc_digit) begin
              fd_accum = {28'd0, fc[3:0]};
              fd_phase = PH_DIGITS;
            end else begin
              fd_failed = 1'b1;
            end
          end
          default: begin
            if (fc == CH_SPACE || fc == CH_TAB || fc == CH_VT || fc == CH_FF) begin
              fd_phase = fd_phase;
            end else if (fc == CH_PLUS || fc == CH_MINUS) begin
              fd_neg   = (fc == CH_MINUS);
              fd_phase = PH_SIGN;
            end else if (fc_digit) begin
              fd_accum = {28'd0, fc[3:0]};
              fd_phase = PH_DIGITS;
            end else begin
              fd_failed = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (feed_en && fd_we) begin
      pend_d[field_q[FIELD_W-1:0]] = commit_val;
    end
  end

  // line control, keyword search and decode
  always_comb begin
    logic [2:0] p;
    logic       clear;
    logic       eff_failed;
    logic [FIELD_W-1:0] eff_field;
    pos_d       = pos_q;
    lead_d      = lead_q;
    ended_d     = ended_q;
    prog_d      = prog_q;
    found_d     = found_q;
    held_d      = held_q;
    hvalid_d    = hvalid_q;
    reply_d     = reply_q;
    status_d    = status_q;
    kind_d      = kind_q;
    res_valid_d = res_valid_q && !res_ready_i;
    feed_en     = 1'b0;
    clear       = 1'b0;
    p           = '0;
    eff_failed  = failed_q;
    eff_field   = field_q;
    if (rx_xfer && rx_byte_i != CH_CR) begin
      if (rx_byte_i == CH_LF) begin
        feed_en    = !ended_q;
        eff_failed = feed_en ? fd_failed : failed_q;
        eff_field  = feed_en ? fd_field : field_q;
        clear       = 1'b1;
        res_valid_d = 1'b1;
        kind_d      = KIND_IGNORED;
        if (lead_q == CH_O) begin
          reply_d = REPLY_OK;
          kind_d  = KIND_RESPONSE;
        end else if (lead_q == CH_F) begin
          reply_d = REPLY_FAIL;
          kind_d  = KIND_RESPONSE;
        end else if (lead_q == CH_A) begin
          reply_d = REPLY_ARRIVED;
          kind_d  = KIND_RESPONSE;
        end else if (lead_q == CH_B) begin
          if (!eff_failed && eff_field >= FIELD_W'(FIELDS)) begin
            held_d   = pend_d;
            hvalid_d = 1'b1;
            kind_d   = KIND_BROADCAST;
          end
        end else if (lead_q == CH_S) begin
          if (found_q[WORD_STOPPED])     status_d = STAT_STOPPED;
          else if (found_q[WORD_MOVING]) status_d = STAT_MOVING;
          else if (found_q[WORD_PAUSED]) status_d = STAT_PAUSED;
          else                           status_d = STAT_UNKNOWN;
          kind_d = KIND_STATUS;
        end
      end else if (pos_q >= POS_W'(LINE_BYTES - 1)) begin
        clear = 1'b1;
      end else begin
        if (pos_q == '0) begin
          lead_d = rx_byte_i;
        end
        pos_d = pos_q + POS_W'(1);
        if (!ended_q) begin
          if (rx_byte_i == CH_NUL) begin
            ended_d = 1'b1;
            feed_en = 1'b1;
          end else begin
            feed_en = (pos_q != '0);
            for (int w = 0; w < 3; w++) begin
              if (!found_q[w]) begin
                if (rx_byte_i == word_char(word_e'(w), prog_q[w])) begin
                  p = prog_q[w] + 3'd1;
                end else begin
                  p = (rx_byte_i == word_char(word_e'(w), 3'd0)) ? 3'd1 : 3'd0;
                end
                if (p == word_len(word_e'(w))) begin
                  found_d[w] = 1'b1;
                  p = 3'd0;
                end
                prog_d[w] = p;
              end
            end
          end
        end
      end
    end
    if (clear) begin
      pos_d   = '0;
      lead_d  = CH_NUL;
      ended_d = 1'b0;
      for (int w = 0; w < 3; w++) begin
        prog_d[w] = '0;
      end
      found_d = '0;
    end
    field_d  = clear ? '0 : (feed_en ? fd_field : field_q);
    phase_d  = clear ? PH_IDLE : (feed_en ? fd_phase : phase_q);
    neg_d    = clear ? 1'b0 : (feed_en ? fd_neg : neg_q);
    accum_d  = clear ? '0 : (feed_en ? fd_accum : accum_q);
    failed_d = clear ? 1'b0 : (feed_en ? fd_failed : failed_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      lead_q      <= CH_NUL;
      ended_q     <= 1'b0;
      field_q     <= '0;
      phase_q     <= PH_IDLE;
      neg_q       <= 1'b0;
      accum_q     <= '0;
      failed_q    <= 1'b0;
      for (int w = 0; w < 3; w++) begin
        prog_q[w] <= '0;
      end
      found_q     <= '0;
      for (int i = 0; i < FIELDS; i++) begin
        held_q[i] <= '0;
      end
      hvalid_q    <= 1'b0;
      reply_q     <= REPLY_NONE;
      status_q    <= STAT_UNKNOWN;
      kind_q      <= KIND_IGNORED;
      res_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      lead_q      <= lead_d;
      ended_q     <= ended_d;
      field_q     <= field_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      accum_q     <= accum_d;
      failed_q    <= failed_d;
      prog_q      <= prog_d;
      found_q     <= found_d;
      held_q      <= held_d;
      hvalid_q    <= hvalid_d;
      reply_q     <= reply_d;
      status_q    <= status_d;
      kind_q      <= kind_d;
      res_valid_q <= res_valid_d;
    end
  end

  // pending values are only read once all six have been written in the line
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  assign res_valid_o     = res_valid_q;
  assign line_kind_o     = kind_q;
  assign last_reply_o    = reply_q;
  assign motion_status_o = status_q;
  assign pose_x_o        = $signed(held_q[0]);
  assign pose_y_o        = $signed(held_q[1]);
  assign pose_heading_o  = $signed(held_q[2]);
  assign speed_x_o       = $signed(held_q[3]);
  assign speed_y_o       = $signed(held_q[4]);
  assign speed_heading_o = $signed(held_q[5]);
  assign pose_valid_o    = hvalid_q;

  `MRLP_ASSERT_NEXT(a_stall_holds, res_valid_o && !res_ready_i,
    $stable(pose_x_o) && $stable(speed_heading_o) && $stable(line_kind_o)
    && $stable(last_reply_o) && $stable(motion_status_o), "result changed while stalled")
  `MRLP_ASSERT_NEXT(a_newline_result, rx_xfer && rx_byte_i == CH_LF, res_valid_o,
    "newline transfer gave no result")
  `MRLP_ASSERT_NEXT(a_no_spurious, rx_xfer && rx_byte_i != CH_LF, !res_valid_o,
    "result without a newline")
  `MRLP_ASSERT_NOW(a_pos_bound, 1'b1, pos_q <= POS_W'(LINE_BYTES - 1),
    "line position beyond buffer")
  `MRLP_ASSERT_NOW(a_valid_sticky, 1'b1, !$fell(pose_valid_o), "pose valid dropped")

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// motion reply line parser testbench
// streams reply, broadcast, status, broken and noise lines into the parser one
// byte per transfer, predicts each line result in a model of its own and
// checks every result field by field under random sender and receiver idling
// ----------------------------------------------------------------------------
module testbench
  import mrlp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [1:0]                  reply;
    logic [1:0]                  status;
    logic [FIELDS-1:0][31:0]     vals;
    logic                        valid;
  } line_result_t;

  typedef struct {
    logic [7:0] data;
    bit         drain;
  } rx_item_t;

  typedef enum {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               rx_valid_i = 1'b0;
  logic               rx_ready_o;
  logic [7:0]         rx_byte_i = '0;
  logic               res_valid_o;
  logic               res_ready_i = 1'b0;
  logic [1:0]         line_kind_o;
  logic [1:0]         last_reply_o;
  logic [1:0]         motion_status_o;
  logic signed [31:0] pose_x_o;
  logic signed [31:0] pose_y_o;
  logic signed [31:0] pose_heading_o;
  logic signed [31:0] speed_x_o;
  logic signed [31:0] speed_y_o;
  logic signed [31:0] speed_heading_o;
  logic               pose_valid_o;

  motion_reply_line_parser_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_valid_i      (rx_valid_i),
    .rx_ready_o      (rx_ready_o),
    .rx_byte_i       (rx_byte_i),
    .res_valid_o     (res_valid_o),
    .res_ready_i     (res_ready_i),
    .line_kind_o     (line_kind_o),
    .last_reply_o    (last_reply_o),
    .motion_status_o (motion_status_o),
    .pose_x_o        (pose_x_o),
    .pose_y_o        (pose_y_o),
    .pose_heading_o  (pose_heading_o),
    .speed_x_o       (speed_x_o),
    .speed_y_o       (speed_y_o),
    .speed_heading_o (speed_heading_o),
    .pose_valid_o    (pose_valid_o)
  );

  // line decoder state
  int unsigned             line_pos = 0;
  logic [7:0]              lead = CH_NUL;
  bit                      content_done = 1'b0;
  int unsigned             field_cnt = 0;
  phase_e                  num_phase = PH_IDLE;
  bit                      num_neg = 1'b0;
  logic [63:0]             num_acc = '0;
  bit                      parse_bad = 1'b0;
  logic [FIELDS-1:0][31:0] field_vals = '0;
  int unsigned             word_prog [3] = '{0, 0, 0};
  bit                      word_hit [3] = '{0, 0, 0};
  logic [FIELDS-1:0][31:0] held_vals = '0;
  bit                      held_ok = 1'b0;
  reply_e                  held_reply = REPLY_NONE;
  status_e                 held_status = STAT_UNKNOWN;

  string kw_text [3] = '{"STOPPED", "MOVING", "PAUSED"};
  string value_names [FIELDS] = '{"pose_x", "pose_y", "pose_heading",
                                  "speed_x", "speed_y", "speed_heading"};
  string status_words [9] = '{"STOPPED", "MOVING", "PAUSED", "STOPPE", "MOVIN",
                              "PAUSE", "SSTOPPED", "PAUSMOVING", "STOPPAUSED"};
  logic [7:0] blanks [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};

  rx_item_t     rx_stim_q [$];
  line_result_t expected_lines [$];
  logic [7:0]   line_buf [$];
  bit           drain_next = 1'b0;
  int unsigned  byte_cnt = 0;
  int unsigned  rx_sent = 0;
  int unsigned  rx_accepted = 0;
  int unsigned  results_seen = 0;
  int unsigned  errors = 0;

  function automatic void clear_line_state();
    line_pos     = 0;
    lead         = CH_NUL;
    content_done = 1'b0;
    field_cnt    = 0;
    num_phase    = PH_IDLE;
    num_neg      = 1'b0;
    num_acc      = '0;
    parse_bad    = 1'b0;
    field_vals   = '0;
    word_prog    = '{0, 0, 0};
    word_hit     = '{0, 0, 0};
  endfunction

  // number scanner, a zero byte marks the end of the content
  function automatic void feed_field(input logic [7:0] c);
    bit          digit;
    logic [31:0] v;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (parse_bad || field_cnt >= FIELDS) return;
    if (num_phase == PH_DIGITS) begin
      if (digit) begin
        num_acc = num_acc * 64'd10 + 64'(c - CH_ZERO);
        if (num_acc > {32'd0, NUM_SAT}) num_acc = {32'd0, NUM_SAT};
        return;
      end
      if (num_neg) begin
        v = 32'd0 - num_acc[31:0];
      end else begin
        v = (num_acc > {32'd0, INT_MAX}) ? INT_MAX : num_acc[31:0];
      end
      field_vals[field_cnt] = v;
      field_cnt++;
      num_phase = PH_IDLE;
      num_neg   = 1'b0;
      num_acc   = '0;
      if (field_cnt >= FIELDS) return;
    end
    if (num_phase == PH_SIGN) begin
      if (digit) begin
        num_acc   = 64'(c - CH_ZERO);
        num_phase = PH_DIGITS;
      end else begin
        parse_bad = 1'b1;
      end
      return;
    end
    if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) return;
    if (c == CH_PLUS || c == CH_MINUS) begin
      num_neg   = (c == CH_MINUS);
      num_phase = PH_SIGN;
    end else if (digit) begin
      num_acc   = 64'(c - CH_ZERO);
      num_phase = PH_DIGITS;
    end else begin
      parse_bad = 1'b1;
    end
  endfunction

  // returns 1 when the byte closes a line, with the line result
  function automatic bit decode_rx_byte(input logic [7:0] c, output line_result_t r);
    line_kind_e  kind;
    int unsigned p;
    if (c == CH_CR) return 1'b0;
    if (c != CH_LF) begin
      if (line_pos >= LINE_BYTES - 1) begin
        clear_line_state();
        return 1'b0;
      end
      if (line_pos == 0) lead = c;
      line_pos++;
      if (content_done) return 1'b0;
      if (c == CH_NUL) begin
        content_done = 1'b1;
        feed_field(CH_NUL);
        return 1'b0;
      end
      for (int w = 0; w < 3; w++) begin
        if (!word_hit[w]) begin
          p = word_prog[w];
          if (c == kw_text[w][p]) p++;
          else p = (c == kw_text[w][0]) ? 1 : 0;
          if (p >= kw_text[w].len()) begin
            word_hit[w] = 1'b1;
            p = 0;
          end
          word_prog[w] = p;
        end
      end
      if (line_pos > 1) feed_field(c);
      return 1'b0;
    end
    if (!content_done) feed_field(CH_NUL);
    kind = KIND_IGNORED;
    case (lead)
      CH_O: begin
        held_reply = REPLY_OK;
        kind = KIND_RESPONSE;
      end
      CH_F: begin
        held_reply = REPLY_FAIL;
        kind = KIND_RESPONSE;
      end
      CH_A: begin
        held_reply = REPLY_ARRIVED;
        kind = KIND_RESPONSE;
      end
      CH_B: begin
        if (!parse_bad && field_cnt >= FIELDS) begin
          held_vals = field_vals;
          held_ok   = 1'b1;
          kind      = KIND_BROADCAST;
        end
      end
      CH_S: begin
        if (word_hit[WORD_STOPPED]) held_status = STAT_STOPPED;
        else if (word_hit[WORD_MOVING]) held_status = STAT_MOVING;
        else if (word_hit[WORD_PAUSED]) held_status = STAT_PAUSED;
        else held_status = STAT_UNKNOWN;
        kind = KIND_STATUS;
      end
      default: ;
    endcase
    r.kind   = kind;
    r.reply  = held_reply;
    r.status = held_status;
    r.vals   = held_vals;
    r.valid  = held_ok;
    clear_line_state();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // stimulus building
  task automatic push_byte(input logic [7:0] b);
    rx_item_t it;
    it.data = b;
    it.drain = drain_next;
    rx_stim_q.push_back(it);
    drain_next = 1'b0;
    byte_cnt++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_blanks(input int unsigned lo);
    repeat ($urandom_range(lo, 3)) line_buf.push_back(blanks[$urandom_range(0, 3)]);
  endtask

  task automatic flush_line(input bit crlf);
    foreach (line_buf[i]) push_byte(line_buf[i]);
    if (crlf) push_byte(CH_CR);
    push_byte(CH_LF);
    line_buf.delete();
  endtask

  task automatic text_line(input string s);
    add_text(s);
    flush_line(1'b0);
  endtask

  function automatic string rand_number_text();
    string mag;
    string sgn;
    case ($urandom_range(0, 4))
      0: mag = $sformatf("%0d", $urandom_range(0, 9));
      1: mag = $sformatf("%0d", $urandom_range(0, 99999));
      2: mag = $sformatf("%0d", $urandom);
      3: mag = {"000", $sformatf("%0d", $urandom_range(0, 999))};
      default: mag = {"9", $sformatf("%0d%0d", $urandom, $urandom_range(0, 9))};
    endcase
    case ($urandom_range(0, 2))
      0: sgn = "-";
      1: sgn = "+";
      default: sgn = "";
    endcase
    return {sgn, mag};
  endfunction

  task automatic add_broadcast(input int unsigned n);
    line_buf.push_back(CH_B);
    repeat (n) begin
      add_blanks(($urandom_range(0, 7) == 0) ? 0 : 1);
      add_text(rand_number_text());
    end
  endtask

  task automatic build_directed();
    text_line("O");
    add_text("F");
    flush_line(1'b1);
    text_line("A");
    text_line("");
    text_line("X?");
    text_line("B 1 -2 +3 4 5 6");
    text_line("B 2147483647 -2147483648 2147483648 -2147483649 99999999999 -0");
    add_text("B1-2+3");
    line_buf.push_back(CH_TAB);
    add_text("4");
    line_buf.push_back(CH_VT);
    add_text("5");
    line_buf.push_back(CH_FF);
    add_text("6 tail");
    flush_line(1'b0);
    text_line("B 1 2 3 4 5");
    text_line("B 1 2 + 3 4 5");
    drain_next = 1'b1;
    text_line("B 1 2 x 4 5 6");
    add_text("B 7 8 9");
    line_buf.push_back(CH_NUL);
    add_text(" 10 11 12");
    flush_line(1'b0);
    text_line("SPAUSED MOVING STOPPED");
    text_line("S MOVING PAUSED");
    text_line("S xPAUSED");
    text_line("SSTOSTOPPED");
    text_line("S PAUSE MOVIN");
    line_buf.push_back(CH_NUL);
    text_line("B 1 2 3 4 5 6");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h80);
    flush_line(1'b0);
    // longest line that still fits, then two bytes too many
    add_text("A");
    repeat (LINE_BYTES - 2) add_text("y");
    flush_line(1'b0);
    add_text("S");
    repeat (LINE_BYTES - 2) add_text("x");
    add_text("zF");
    flush_line(1'b0);
  endtask

  task automatic build_random();
    int unsigned pick;
    int unsigned m;
    while (byte_cnt < 550) begin
      if ($urandom_range(0, 14) == 0) drain_next = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        add_broadcast(FIELDS);
        if ($urandom_range(0, 3) == 0) add_text(" end");
      end else if (pick < 47) begin
        add_broadcast($urandom_range(0, FIELDS));
        m = $urandom_range(0, 3);
        case (m)
          0: line_buf.insert($urandom_range(1, line_buf.size()),
                             8'($urandom_range(0, 255)));
          1: begin
            line_buf.insert($urandom_range(1, line_buf.size()), CH_SPACE);
            line_buf.insert($urandom_range(1, line_buf.size()), CH_MINUS);
          end
          2: line_buf.insert($urandom_range(1, line_buf.size()), CH_NUL);
          default: line_buf.insert($urandom_range(1, line_buf.size()), CH_CR);
        endcase
      end else if (pick < 67) begin
        line_buf.push_back(CH_S);
        repeat ($urandom_range(0, 3)) begin
          add_blanks(0);
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(65, 90)));
          end else begin
            add_text(status_words[$urandom_range(0, 8)]);
          end
        end
      end else if (pick < 82) begin
        case ($urandom_range(0, 2))
          0: line_buf.push_back(CH_O);
          1: line_buf.push_back(CH_F);
          default: line_buf.push_back(CH_A);
        endcase
        repeat ($urandom_range(0, 6)) line_buf.push_back(8'($urandom_range(32, 126)));
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        line_buf.push_back(blanks[$urandom_range(0, 3)]);
      end else if (pick < 98) begin
        ;
      end else begin
        line_buf.push_back(($urandom_range(0, 1) == 0) ? CH_B : CH_S);
        repeat ($urandom_range(LINE_BYTES - 2, LINE_BYTES + 12))
          line_buf.push_back(8'($urandom_range(32, 126)));
      end
      flush_line(1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // sender: bursts with random gaps, holds each byte until its transfer
  always @(negedge clk_i) begin : drive_rx
    int unsigned burst_left;
    int unsigned gap_left;
    bit          send;
    rx_item_t    it;
    if (rst_ni && !(rx_valid_i && rx_sent != rx_accepted)) begin
      send = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (rx_stim_q.size() > 0) begin
        send = !(rx_stim_q[0].drain && expected_lines.size() != 0);
      end
      if (send) begin
        it = rx_stim_q.pop_front();
        rx_sent++;
        rx_byte_i <= it.data;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
      rx_valid_i <= send;
    end
  end

  // receiver: stall pattern of its own plus one long hold-off
  always @(negedge clk_i) begin : drive_res
    int unsigned hold_left;
    bit          hold_done;
    int unsigned mode_left;
    int unsigned tick;
    ready_mode_e mode;
    bit          rdy;
    tick++;
    if (!rst_ni) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!hold_done && results_seen >= 12) begin
      hold_done = 1'b1;
      hold_left = 400;
      rdy = 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = ready_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (mode)
        READY_ALWAYS:   rdy = 1'b1;
        READY_COIN:     rdy = 1'($urandom_range(0, 1));
        READY_SPARSE:   rdy = ($urandom_range(0, 3) == 0);
        default:        rdy = (tick % 5) != 0;
      endcase
    end
    res_ready_i <= rdy;
  end

  // result checking and prediction of accepted bytes
  always @(posedge clk_i) begin : watch
    line_result_t got;
    line_result_t want;
    if (rst_ni) begin
      if (res_valid_o && res_ready_i) begin
        results_seen++;
        got.kind   = line_kind_o;
        got.reply  = last_reply_o;
        got.status = motion_status_o;
        got.vals   = {speed_heading_o, speed_y_o, speed_x_o,
                      pose_heading_o, pose_y_o, pose_x_o};
        got.valid  = pose_valid_o;
        if (expected_lines.size() == 0) begin
          report_mismatch($sformatf("result with no line pending, line_kind %0d", got.kind));
        end else begin
          want = expected_lines.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("line_kind got %0d expected %0d", got.kind, want.kind));
          if (got.reply !== want.reply)
            report_mismatch($sformatf("last_reply got %0d expected %0d", got.reply,
                                      want.reply));
          if (got.status !== want.status)
            report_mismatch($sformatf("motion_status got %0d expected %0d", got.status,
                                      want.status));
          if (got.valid !== want.valid)
            report_mismatch($sformatf("pose_valid got %0d expected %0d", got.valid,
                                      want.valid));
          for (int i = 0; i < FIELDS; i++) begin
            if (got.vals[i] !== want.vals[i])
              report_mismatch($sformatf("%s got %0d expected %0d", value_names[i],
                                        $signed(got.vals[i]), $signed(want.vals[i])));
          end
        end
      end
      if (rx_valid_i && rx_ready_o) begin
        rx_accepted++;
        if (decode_rx_byte(rx_byte_i, want)) expected_lines.push_back(want);
      end
    end
  end

  initial begin
    build_directed();
    drain_next = 1'b1;
    build_random();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (rx_stim_q.size() == 0);
    @(posedge clk_i);
    wait (!rx_valid_i);
    wait (expected_lines.size() == 0);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
